/* hdl/nga_pkg.sv */
// ----------------------------------------------------------------------------
// nga_pkg
// shared types and constants of the softened direct-sum gravity block
// ----------------------------------------------------------------------------
package nga_pkg;

  localparam int unsigned MaxBodies = 64;
  localparam int unsigned IdxW      = $clog2(MaxBodies);
  localparam int unsigned CntW      = IdxW + 1;

  localparam logic [31:0] GravReset = 32'd662248839;
  localparam logic [31:0] SoftReset = 32'd17;

  localparam logic [0:0] RegGrav = 1'b0;
  localparam logic [0:0] RegSoft = 1'b1;

  localparam logic [46:0] TermMax = {47{1'b1}};

  typedef enum logic [2:0] {
    T_LOAD,
    T_RDI,
    T_LATI,
    T_CHKJ,
    T_LATJ,
    T_PAIR,
    T_OUT
  } top_state_e;

  typedef enum logic [4:0] {
    P_IDLE,
    P_SQM,
    P_SQA,
    P_ZCHK,
    P_ROOT,
    P_GM,
    P_GMA,
    P_DEN0,
    P_DEN1,
    P_DEN2,
    P_NUM0,
    P_NUM1,
    P_NUM2,
    P_OVF,
    P_DIV,
    P_NEXTK,
    P_DONE
  } pair_state_e;

  typedef struct packed {
    logic             done;
    logic             skip;
    logic             clamp;
    logic [2:0]       neg;
    logic [2:0][46:0] term;
  } pair_res_t;

endpackage

/* hdl/nbody_gravity_accel.sv */
// ----------------------------------------------------------------------------
// nbody_gravity_accel
// softened direct-sum gravitational acceleration over a stored body set
// ----------------------------------------------------------------------------
// Bodies come in on the input channel one item each (position, mass), in
// load order, up to 64; an item with last_body set closes the set. Items
// beyond 64 are dropped, but their last_body flag still closes the set.
// After the closing item the block stops taking input and emits one item
// per stored body on the output channel, in load order, with body_index,
// overflow and last_result. Then the set is empty and input opens again.
// Each body pair runs through one sequencer around a shared 33x33
// multiplier, a 32-step square root and up to three 47-step restoring
// divides; a pair that clamps a component skips that divide. Pairs run
// one after another, never overlapped.
// A stalled receiver holds the result in the output register and the
// computation waits. Reset empties the set and loads the register
// defaults; the body memories are not cleared. Configuration writes
// take effect at once and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module nbody_gravity_accel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        body_mass_i,
  input  logic               last_body_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] acc_x_o,
  output logic signed [47:0] acc_y_o,
  output logic signed [47:0] acc_z_o,
  output logic [5:0]         body_index_o,
  output logic               overflow_o,
  output logic               last_result_o
);

  localparam int unsigned IdxW = nga_pkg::IdxW;
  localparam int unsigned CntW = nga_pkg::CntW;

  nga_pkg::top_state_e state_q, state_d;

  logic [31:0]      grav_q, soft_q;
  logic [CntW-1:0]  count_q, n_q, i_q, j_q;
  logic [95:0]      pos_mem [nga_pkg::MaxBodies];
  logic [31:0]      mass_mem [nga_pkg::MaxBodies];
  logic [95:0]      rd_pos_q;
  logic [31:0]      rd_mass_q;
  logic [95:0]      pi_q;
  logic signed [55:0] acc_q [3];
  logic             flag_q;
  logic signed [47:0] out_q [3];
  logic             oflag_q;

  logic             in_acc, out_acc, full, pair_start;
  logic [IdxW-1:0]  rd_addr;
  nga_pkg::pair_res_t pres;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;
  assign full    = (count_q == CntW'(nga_pkg::MaxBodies));

  nga_pair u_pair (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pair_start),
    .pos_a_i (pi_q),
    .pos_b_i (rd_pos_q),
    .mass_i  (rd_mass_q),
    .grav_i  (grav_q),
    .soft_i  (soft_q),
    .res_o   (pres)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nga_pkg::T_LOAD: if (in_acc && last_body_i) state_d = nga_pkg::T_RDI;
      nga_pkg::T_RDI:  state_d = nga_pkg::T_LATI;
      nga_pkg::T_LATI: state_d = nga_pkg::T_CHKJ;
      nga_pkg::T_CHKJ: begin
        if (j_q == n_q) state_d = nga_pkg::T_OUT;
        else if (j_q != i_q) state_d = nga_pkg::T_LATJ;
      end
      nga_pkg::T_LATJ: state_d = nga_pkg::T_PAIR;
      nga_pkg::T_PAIR: if (pres.done) state_d = nga_pkg::T_CHKJ;
      nga_pkg::T_OUT: begin
        if (out_acc) begin
          state_d = (i_q == n_q - CntW'(1)) ? nga_pkg::T_LOAD : nga_pkg::T_RDI;
        end
      end
      default: state_d = nga_pkg::T_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o  = (state_q == nga_pkg::T_LOAD);
    out_valid_o = (state_q == nga_pkg::T_OUT);
    pair_start  = (state_q == nga_pkg::T_LATJ);
    rd_addr     = (state_q == nga_pkg::T_RDI) ? i_q[IdxW-1:0] : j_q[IdxW-1:0];
  end

  // body memories
  always_ff @(posedge clk_i) begin
    if (in_acc && !full) begin
      pos_mem[count_q[IdxW-1:0]]  <= {pos_z_i, pos_y_i, pos_x_i};
      mass_mem[count_q[IdxW-1:0]] <= body_mass_i;
    end
    rd_pos_q  <= pos_mem[rd_addr];
    rd_mass_q <= mass_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nga_pkg::T_LOAD;
      grav_q  <= nga_pkg::GravReset;
      soft_q  <= nga_pkg::SoftReset;
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          nga_pkg::RegGrav: grav_q <= cfg_data_i;
          nga_pkg::RegSoft: soft_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        nga_pkg::T_LOAD: begin
          if (in_acc) begin
            if (!full) count_q <= count_q + CntW'(1);
            if (last_body_i) begin
              n_q <= full ? count_q : count_q + CntW'(1);
              i_q <= '0;
            end
          end
        end
        nga_pkg::T_LATI: j_q <= '0;
        nga_pkg::T_CHKJ: if (j_q == i_q && j_q != n_q) j_q <= j_q + CntW'(1);
        nga_pkg::T_PAIR: if (pres.done) j_q <= j_q + CntW'(1);
        nga_pkg::T_OUT: begin
          if (out_acc) begin
            if (i_q == n_q - CntW'(1)) count_q <= '0;
            else i_q <= i_q + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // accumulation and saturation
  always_ff @(posedge clk_i) begin
    case (state_q)
      nga_pkg::T_LATI: begin
        pi_q   <= rd_pos_q;
        flag_q <= 1'b0;
        for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      end
      nga_pkg::T_PAIR: begin
        if (pres.done) begin
          flag_q <= flag_q | pres.skip | pres.clamp;
          if (!pres.skip) begin
            for (int k = 0; k < 3; k++) begin
              if (pres.neg[k]) acc_q[k] <= acc_q[k] + 56'(pres.term[k]);
              else acc_q[k] <= acc_q[k] - 56'(pres.term[k]);
            end
          end
        end
      end
      nga_pkg::T_CHKJ: begin
        if (j_q == n_q) begin
          logic sat;
          sat = 1'b0;
          for (int k = 0; k < 3; k++) begin
            if (acc_q[k] > 56'sh7FFF_FFFF_FFFF) begin
              out_q[k] <= 48'sh7FFF_FFFF_FFFF;
              sat = 1'b1;
            end else if (acc_q[k] < -56'sh8000_0000_0000) begin
              out_q[k] <= 48'sh8000_0000_0000;
              sat = 1'b1;
            end else begin
              out_q[k] <= acc_q[k][47:0];
            end
          end
          oflag_q <= flag_q | sat;
        end
      end
      default: ;
    endcase
  end

  assign acc_x_o       = out_q[0];
  assign acc_y_o       = out_q[1];
  assign acc_z_o       = out_q[2];
  assign body_index_o  = i_q[IdxW-1:0];
  assign overflow_o    = oflag_q;
  assign last_result_o = (i_q == n_q - CntW'(1));

endmodule

/* hdl/nga_mul.sv */
// ----------------------------------------------------------------------------
// nga_mul
// shared 33x33 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module nga_mul (
  input  logic        clk_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic [65:0] p_o
);

  logic [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 66'(a_i) * 66'(b_i);
  end

  assign p_o = p_q;

endmodule

/* hdl/nga_pair.sv */
// ----------------------------------------------------------------------------
// nga_pair
// sequencer for one body pair: distance, root, denominator and three divides
// ----------------------------------------------------------------------------
module nga_pair (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [95:0]         pos_a_i,
  input  logic [95:0]         pos_b_i,
  input  logic [31:0]         mass_i,
  input  logic [31:0]         grav_i,
  input  logic [31:0]         soft_i,
  output nga_pkg::pair_res_t  res_o
);

  nga_pkg::pair_state_e state_q, state_d;

  logic [4:0]       cnt_q;
  logic [5:0]       dcnt_q;
  logic [1:0]       k_q;
  logic [32:0]      mag_q [3];
  logic [2:0]       neg_q;
  logic [31:0]      m_q;
  logic [41:0]      sq_q;
  logic [63:0]      v_q;
  logic [63:0]      res_q;
  logic [63:0]      gm_q;
  logic [79:0]      den_q;
  logic [96:0]      num_q;
  logic [80:0]      rem_q;
  logic [46:0]      nl_q;
  logic [46:0]      quo_q;
  logic [2:0][46:0] term_q;
  logic             clamp_q;
  logic             skip_q;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;

  logic [63:0] rt_bit, rt_sum;
  logic [80:0] dv_t;
  logic [46:0] quo_n;
  logic [47:0] sq6;

  nga_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign sq6    = {sq_q, 6'b0};
  assign rt_bit = 64'(1) << (6'd62 - {cnt_q, 1'b0});
  assign rt_sum = res_q + rt_bit;
  assign dv_t   = {rem_q[79:0], nl_q[46]};
  assign quo_n  = {quo_q[45:0], (dv_t >= {1'b0, den_q})};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nga_pkg::P_IDLE:  if (start_i) state_d = nga_pkg::P_SQM;
      nga_pkg::P_SQM:   state_d = nga_pkg::P_SQA;
      nga_pkg::P_SQA:   state_d = (k_q == 2'd2) ? nga_pkg::P_ZCHK : nga_pkg::P_SQM;
      nga_pkg::P_ZCHK:  state_d = (sq_q == '0) ? nga_pkg::P_DONE : nga_pkg::P_ROOT;
      nga_pkg::P_ROOT:  if (cnt_q == 5'd31) state_d = nga_pkg::P_GM;
      nga_pkg::P_GM:    state_d = nga_pkg::P_GMA;
      nga_pkg::P_GMA:   state_d = nga_pkg::P_DEN0;
      nga_pkg::P_DEN0:  state_d = nga_pkg::P_DEN1;
      nga_pkg::P_DEN1:  state_d = nga_pkg::P_DEN2;
      nga_pkg::P_DEN2:  state_d = nga_pkg::P_NUM0;
      nga_pkg::P_NUM0:  state_d = nga_pkg::P_NUM1;
      nga_pkg::P_NUM1:  state_d = nga_pkg::P_NUM2;
      nga_pkg::P_NUM2:  state_d = nga_pkg::P_OVF;
      nga_pkg::P_OVF: begin
        if ({30'b0, num_q[96:47]} >= den_q) state_d = nga_pkg::P_NEXTK;
        else state_d = nga_pkg::P_DIV;
      end
      nga_pkg::P_DIV:   if (dcnt_q == 6'd46) state_d = nga_pkg::P_NEXTK;
      nga_pkg::P_NEXTK: state_d = (k_q == 2'd2) ? nga_pkg::P_DONE : nga_pkg::P_NUM0;
      nga_pkg::P_DONE:  state_d = nga_pkg::P_IDLE;
      default:          state_d = nga_pkg::P_IDLE;
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      nga_pkg::P_SQM: begin
        mul_a = mag_q[k_q];
        mul_b = mag_q[k_q];
      end
      nga_pkg::P_GM: begin
        mul_a = 33'(grav_i);
        mul_b = 33'(m_q);
      end
      nga_pkg::P_DEN0: begin
        mul_a = sq6[32:0];
        mul_b = 33'(res_q[30:0]);
      end
      nga_pkg::P_DEN1: begin
        mul_a = 33'(sq6[47:33]);
        mul_b = 33'(res_q[30:0]);
      end
      nga_pkg::P_NUM0: begin
        mul_a = gm_q[32:0];
        mul_b = mag_q[k_q];
      end
      nga_pkg::P_NUM1: begin
        mul_a = 33'(gm_q[63:33]);
        mul_b = mag_q[k_q];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nga_pkg::P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      nga_pkg::P_IDLE: begin
        if (start_i) begin
          for (int k = 0; k < 3; k++) begin
            logic [32:0] d;
            d = {pos_a_i[32*k+31], pos_a_i[32*k +: 32]}
              - {pos_b_i[32*k+31], pos_b_i[32*k +: 32]};
            neg_q[k] <= d[32];
            mag_q[k] <= d[32] ? (33'd0 - d) : d;
          end
          m_q     <= mass_i;
          sq_q    <= 42'(soft_i);
          k_q     <= 2'd0;
          clamp_q <= 1'b0;
          skip_q  <= 1'b0;
        end
      end
      nga_pkg::P_SQA: begin
        sq_q <= sq_q + prod[65:24];
        k_q  <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      nga_pkg::P_ZCHK: begin
        if (sq_q == '0) skip_q <= 1'b1;
        v_q   <= {2'b0, sq_q, 20'b0};
        res_q <= '0;
        cnt_q <= '0;
      end
      nga_pkg::P_ROOT: begin
        if (v_q >= rt_sum) begin
          v_q   <= v_q - rt_sum;
          res_q <= (res_q >> 1) + rt_bit;
        end else begin
          res_q <= res_q >> 1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
      nga_pkg::P_GMA:  gm_q <= prod[63:0];
      nga_pkg::P_DEN1: den_q <= 80'(prod);
      nga_pkg::P_DEN2: den_q <= den_q + {prod[46:0], 33'b0};
      nga_pkg::P_NUM1: num_q <= 97'(prod);
      nga_pkg::P_NUM2: num_q <= num_q + {prod[63:0], 33'b0};
      nga_pkg::P_OVF: begin
        if ({30'b0, num_q[96:47]} >= den_q) begin
          term_q[k_q] <= nga_pkg::TermMax;
          clamp_q     <= 1'b1;
        end
        rem_q  <= 81'(num_q[96:47]);
        nl_q   <= num_q[46:0];
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      nga_pkg::P_DIV: begin
        rem_q  <= (dv_t >= {1'b0, den_q}) ? dv_t - {1'b0, den_q} : dv_t;
        nl_q   <= {nl_q[45:0], 1'b0};
        quo_q  <= quo_n;
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd46) term_q[k_q] <= quo_n;
      end
      nga_pkg::P_NEXTK: k_q <= k_q + 2'd1;
      default: ;
    endcase
  end

  assign res_o.done  = (state_q == nga_pkg::P_DONE);
  assign res_o.skip  = skip_q;
  assign res_o.clamp = clamp_q;
  assign res_o.neg   = neg_q;
  assign res_o.term  = term_q;

endmodule
